/* hw/rtl/cdq_pkg.sv */
`default_nettype none

package cdq_pkg;

    // Fixed field widths of the command and response transactions.
    localparam int CMD_W   = 3;
    localparam int INDEX_W = 12;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 11;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_READ_AT    = 3'd4,
        CMD_WRITE_AT   = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // Response fields known at issue time; the element itself comes from the RAM.
    typedef struct packed {
        logic                data_valid;
        logic [COUNT_W-1:0]  count_after;
        status_t             status;
    } meta_t;

endpackage

`default_nettype wire

/* hw/rtl/cdq_if.sv */
`default_nettype none

interface cdq_req_if;
    logic                                valid;
    logic                                ready;
    logic [cdq_pkg::CMD_W-1:0]           cmd;
    logic signed [cdq_pkg::INDEX_W-1:0]  index;
    logic [cdq_pkg::VALUE_W-1:0]         value;

    modport source (output valid, cmd, index, value, input ready);
    modport sink   (input valid, cmd, index, value, output ready);
endinterface

interface cdq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [cdq_pkg::VALUE_W-1:0]   data_out;
    logic                          data_valid;
    logic [cdq_pkg::COUNT_W-1:0]   count_after;
    logic [1:0]                    status;

    modport source (output valid, data_out, data_valid, count_after, status, input ready);
    modport sink   (input valid, data_out, data_valid, count_after, status, output ready);
endinterface

`default_nettype wire

/* hw/rtl/cdq_mem.sv */
`default_nettype none

// Single-port RAM, read-first, registered read data.
module cdq_mem #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                      clk,
    input  wire logic                      en,
    input  wire logic                      we,
    input  wire logic [$clog2(DEPTH)-1:0]  addr,
    input  wire logic [DATA_WIDTH-1:0]     wdata,
    output logic      [DATA_WIDTH-1:0]     rdata
);

    logic [DATA_WIDTH-1:0] store_reg [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                store_reg[addr] <= wdata;
            end
            rdata_reg <= store_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hw/rtl/cdq_ctrl.sv */
`default_nettype none

// Front pointer / count registers, command decode and RAM access generation.
module cdq_ctrl #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 fire,
    input  wire logic [cdq_pkg::CMD_W-1:0]            cmd,
    input  wire logic signed [cdq_pkg::INDEX_W-1:0]   index,
    input  wire logic [cdq_pkg::VALUE_W-1:0]          value,
    output logic                                      mem_we,
    output logic      [$clog2(DEPTH)-1:0]             mem_addr,
    output logic      [DATA_WIDTH-1:0]                mem_wdata,
    output cdq_pkg::meta_t                            meta
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = ((CW > cdq_pkg::INDEX_W) ? CW : cdq_pkg::INDEX_W) + 1;
    localparam logic [AW:0]          DEPTH_V   = (AW+1)'(DEPTH);
    localparam logic [AW-1:0]        LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0]        FULL_CNT  = CW'(DEPTH);
    localparam logic signed [XW-1:0] MINUS_ONE = -XW'(1);

    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;

    logic [AW-1:0]          front_dec, front_inc;
    logic [AW-1:0]          slot_back, slot_last, slot_idx;
    logic [CW-1:0]          count_m1;
    logic                   full, empty;
    logic signed [XW-1:0]   idx_x, cnt_x;
    logic [CW+cdq_pkg::COUNT_W-1:0]       count_pad;
    logic [DATA_WIDTH+cdq_pkg::VALUE_W-1:0] value_pad;
    cdq_pkg::cmd_t          op;
    cdq_pkg::status_t       status;
    logic                   dvalid;

    // (front + pos) mod DEPTH, both operands already below DEPTH
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] sum;
        logic [AW:0] red;
        sum = {1'b0, a} + {1'b0, b};
        red = (sum >= DEPTH_V) ? (sum - DEPTH_V) : sum;
        return red[AW-1:0];
    endfunction

    assign full      = (count_reg == FULL_CNT);
    assign empty     = (count_reg == '0);
    assign count_m1  = count_reg - CW'(1);
    assign front_dec = (front_reg == '0) ? LAST_SLOT : (front_reg - AW'(1));
    assign front_inc = (front_reg == LAST_SLOT) ? '0 : (front_reg + AW'(1));
    assign idx_x     = XW'(index);
    assign cnt_x     = signed'(XW'(count_reg));
    assign slot_back = wrap_add(front_reg, count_reg[AW-1:0]);
    assign slot_last = wrap_add(front_reg, count_m1[AW-1:0]);
    assign slot_idx  = wrap_add(front_reg, idx_x[AW-1:0]);
    assign value_pad = {{DATA_WIDTH{1'b0}}, value};
    assign mem_wdata = value_pad[DATA_WIDTH-1:0];
    assign op        = cdq_pkg::cmd_t'(cmd);

    always_comb
    begin
        mem_we     = 1'b0;
        mem_addr   = front_reg;
        dvalid     = 1'b0;
        status     = cdq_pkg::ST_OK;
        front_next = front_reg;
        count_next = count_reg;
        case (op)
            cdq_pkg::CMD_PUSH_FRONT:
            begin
                if (full)
                begin
                    status = cdq_pkg::ST_FULL;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_addr   = front_dec;
                    front_next = front_dec;
                    count_next = count_reg + CW'(1);
                end
            end
            cdq_pkg::CMD_PUSH_BACK:
            begin
                if (full)
                begin
                    status = cdq_pkg::ST_FULL;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_addr   = slot_back;
                    count_next = count_reg + CW'(1);
                end
            end
            cdq_pkg::CMD_POP_FRONT:
            begin
                if (empty)
                begin
                    status = cdq_pkg::ST_EMPTY;
                end
                else
                begin
                    dvalid     = 1'b1;
                    mem_addr   = front_reg;
                    front_next = front_inc;
                    count_next = count_m1;
                end
            end
            cdq_pkg::CMD_POP_BACK:
            begin
                if (empty)
                begin
                    status = cdq_pkg::ST_EMPTY;
                end
                else
                begin
                    dvalid     = 1'b1;
                    mem_addr   = slot_last;
                    count_next = count_m1;
                end
            end
            cdq_pkg::CMD_READ_AT:
            begin
                if (idx_x < 0 || idx_x >= cnt_x)
                begin
                    status = cdq_pkg::ST_RANGE;
                end
                else
                begin
                    dvalid   = 1'b1;
                    mem_addr = slot_idx;
                end
            end
            cdq_pkg::CMD_WRITE_AT:
            begin
                if (idx_x == cnt_x)
                begin
                    // pushing write at the back
                    if (full)
                    begin
                        status = cdq_pkg::ST_FULL;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_addr   = slot_back;
                        count_next = count_reg + CW'(1);
                    end
                end
                else if (idx_x == MINUS_ONE)
                begin
                    // pushing write at the front
                    if (full)
                    begin
                        status = cdq_pkg::ST_FULL;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_addr   = front_dec;
                        front_next = front_dec;
                        count_next = count_reg + CW'(1);
                    end
                end
                else if (idx_x < 0 || idx_x > cnt_x)
                begin
                    status = cdq_pkg::ST_RANGE;
                end
                else
                begin
                    // replace; RAM is read-first so the old element comes back
                    mem_we   = 1'b1;
                    dvalid   = 1'b1;
                    mem_addr = slot_idx;
                end
            end
            default:
            begin
                status = cdq_pkg::ST_OK;
            end
        endcase
    end

    assign count_pad        = {{cdq_pkg::COUNT_W{1'b0}}, count_next};
    assign meta.data_valid  = dvalid;
    assign meta.count_after = count_pad[cdq_pkg::COUNT_W-1:0];
    assign meta.status      = status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (fire)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("element count above capacity");

    a_full_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        fire && status == cdq_pkg::ST_FULL |=> $stable(count_reg) && $stable(front_reg))
        else $error("rejected push changed the queue state");

endmodule

`default_nettype wire

/* hw/rtl/circular_deque_with_index_access_unit.sv */
`default_nettype none

// Double-ended queue in a circular RAM of DEPTH elements of DATA_WIDTH bits, with
// push/pop at both ends and read/write at a logical index counted from the front.
// Every command transaction on req yields exactly one response transaction on rsp,
// in order. Throughput is one command per clock while rsp.ready does not hold off
// the pipeline. On its way to the response a command passes the single-port RAM,
// whose read data is registered, then the output register. Front pointer and count
// update at acceptance, and the RAM is read-first, so back-to-back commands on the
// same entry need no forwarding: a replacing write returns the old element.
// Pushes on a full queue, pops on an empty queue and bad indexes are flagged in
// status and leave the queue untouched. data_out is zero whenever data_valid is 0.
// There is no clearing pass after reset; only entries that were pushed are read.
module circular_deque_with_index_access_unit #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cdq_req_if.sink    req,
    cdq_rsp_if.source  rsp
);

    localparam int AW = $clog2(DEPTH);

    // issue stage -> RAM access
    logic                  fire;
    logic                  mem_we;
    logic [AW-1:0]         mem_addr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [DATA_WIDTH-1:0] mem_rdata;
    cdq_pkg::meta_t        meta;

    // stage 1: RAM read in flight, response metadata held alongside
    logic            s1_valid_reg, s1_valid_next;
    cdq_pkg::meta_t  s1_meta_reg;
    logic            s1_adv;

    // output register
    logic                          out_valid_reg, out_valid_next;
    logic [cdq_pkg::VALUE_W-1:0]   out_data_reg;
    cdq_pkg::meta_t                out_meta_reg;
    logic [DATA_WIDTH+cdq_pkg::VALUE_W-1:0] rdata_pad;

    // Stage 1 moves on when the output register is empty or being drained.
    // The RAM read data only changes on a new acceptance, so it holds while
    // stage 1 is stalled.
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_adv;
    assign fire      = req.valid && req.ready;

    cdq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .cmd       (req.cmd),
        .index     (req.index),
        .value     (req.value),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .meta      (meta)
    );

    cdq_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .clk   (clk),
        .en    (fire),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign rdata_pad = {{cdq_pkg::VALUE_W{1'b0}}, mem_rdata};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s1_meta_reg <= meta;
        end
        if (s1_adv)
        begin
            out_meta_reg <= s1_meta_reg;
            out_data_reg <= s1_meta_reg.data_valid ?
                            rdata_pad[cdq_pkg::VALUE_W-1:0] : '0;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.data_out    = out_data_reg;
    assign rsp.data_valid  = out_meta_reg.data_valid;
    assign rsp.count_after = out_meta_reg.count_after;
    assign rsp.status      = out_meta_reg.status;

    a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |-> !fire)
        else $error("command accepted while stage 1 was stalled");

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> s1_valid_reg)
        else $error("accepted command lost before the RAM stage");

    a_error_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != cdq_pkg::ST_OK |-> !rsp.data_valid && rsp.data_out == '0)
        else $error("flagged response carries an element");

endmodule

`default_nettype wire

/* sim/cdq_checker.sv */
`default_nettype none

// Watches both channels, keeps its own copy of the deque and checks every
// response transaction, in order, against the prediction for its command.
module cdq_checker #(
    parameter int DEPTH = 1024
) (
    input  wire logic clk,
    input  wire logic rst_n,
    cdq_req_if        req,
    cdq_rsp_if        rsp,
    output int        errors,
    output int        pending,
    output int        held,
    output int        n_full,
    output int        n_empty,
    output int        n_range
);

    typedef logic [cdq_pkg::VALUE_W-1:0] word_t;

    typedef struct {
        word_t                       data_out;
        logic                        data_valid;
        logic [cdq_pkg::COUNT_W-1:0] count_after;
        cdq_pkg::status_t            status;
    } rsp_fields_t;

    rsp_fields_t        rsp_due[$];
    word_t              ring [DEPTH];
    int                 head;
    int                 rsp_seen;

    function automatic int ring_slot(int pos);
        return (head + pos) % DEPTH;
    endfunction

    function automatic cdq_pkg::status_t put_front(word_t v);
        if (held >= DEPTH)
            return cdq_pkg::ST_FULL;
        head       = (head + DEPTH - 1) % DEPTH;
        ring[head] = v;
        held++;
        return cdq_pkg::ST_OK;
    endfunction

    function automatic cdq_pkg::status_t put_back(word_t v);
        if (held >= DEPTH)
            return cdq_pkg::ST_FULL;
        ring[ring_slot(held)] = v;
        held++;
        return cdq_pkg::ST_OK;
    endfunction

    // Applies one command to the shadow deque and returns its response.
    function automatic rsp_fields_t apply_cmd(logic [cdq_pkg::CMD_W-1:0]          c,
                                              logic signed [cdq_pkg::INDEX_W-1:0] ix,
                                              word_t                              v);
        rsp_fields_t r;
        int          pos;
        int          s;
        r.data_out   = '0;
        r.data_valid = 1'b0;
        r.status     = cdq_pkg::ST_OK;
        pos          = int'(ix);
        case (c)
            cdq_pkg::CMD_PUSH_FRONT: r.status = put_front(v);
            cdq_pkg::CMD_PUSH_BACK:  r.status = put_back(v);
            cdq_pkg::CMD_POP_FRONT, cdq_pkg::CMD_POP_BACK:
                if (held == 0)
                    r.status = cdq_pkg::ST_EMPTY;
                else
                begin
                    s            = (c == cdq_pkg::CMD_POP_FRONT) ? head
                                                                 : ring_slot(held - 1);
                    r.data_out   = ring[s];
                    r.data_valid = 1'b1;
                    if (c == cdq_pkg::CMD_POP_FRONT)
                        head = ring_slot(1);
                    held--;
                end
            cdq_pkg::CMD_READ_AT:
                if (pos < 0 || pos >= held)
                    r.status = cdq_pkg::ST_RANGE;
                else
                begin
                    r.data_out   = ring[ring_slot(pos)];
                    r.data_valid = 1'b1;
                end
            cdq_pkg::CMD_WRITE_AT:
                if (pos == held)
                    r.status = put_back(v);
                else if (pos == -1)
                    r.status = put_front(v);
                else if (pos < -1 || pos > held)
                    r.status = cdq_pkg::ST_RANGE;
                else
                begin
                    s            = ring_slot(pos);
                    r.data_out   = ring[s];
                    r.data_valid = 1'b1;
                    ring[s]      = v;
                end
            default: ;
        endcase
        r.count_after = held[cdq_pkg::COUNT_W-1:0];
        case (r.status)
            cdq_pkg::ST_FULL:  n_full++;
            cdq_pkg::ST_EMPTY: n_empty++;
            cdq_pkg::ST_RANGE: n_range++;
            default: ;
        endcase
        return r;
    endfunction

    task automatic flag_mismatch(string what, word_t got, word_t want);
        errors++;
        $display("MISMATCH rsp #%0d %s: got 0x%0h, expected 0x%0h",
                 rsp_seen, what, got, want);
    endtask

    task automatic check_rsp();
        rsp_fields_t want;
        rsp_seen++;
        if (rsp_due.size() == 0)
            flag_mismatch("response with no command outstanding", rsp.data_out, '0);
        else
        begin
            want = rsp_due.pop_front();
            if (rsp.data_valid !== want.data_valid)
                flag_mismatch("data_valid", word_t'(rsp.data_valid),
                              word_t'(want.data_valid));
            if (rsp.data_out !== want.data_out)
                flag_mismatch("data_out", rsp.data_out, want.data_out);
            if (rsp.count_after !== want.count_after)
                flag_mismatch("count_after", word_t'(rsp.count_after),
                              word_t'(want.count_after));
            if (rsp.status !== 2'(want.status))
                flag_mismatch("status", word_t'(rsp.status), word_t'(want.status));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_due.delete();
            head     = 0;
            held     = 0;
            errors   = 0;
            pending  = 0;
            rsp_seen = 0;
            n_full   = 0;
            n_empty  = 0;
            n_range  = 0;
        end
        else
        begin
            // Response side first: it always belongs to an older command.
            if (rsp.valid && rsp.ready)
                check_rsp();
            if (req.valid && req.ready)
                rsp_due.push_back(apply_cmd(req.cmd, req.index, req.value));
            pending = rsp_due.size();
        end
    end

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`default_nettype none

// Stimulus and verdict for the circular deque. All checking lives in
// cdq_checker; this module only drives commands, paces the response side and
// decides pass/fail from the checker's mismatch count.
module tb_top;

    localparam int DEPTH        = 1024;
    localparam int CYCLE_LIMIT  = 400000;   // many times the slowest legal run
    localparam int STALL_CYCLES = 300;      // long receiver hold-off
    localparam int TAIL_CYCLES  = 8;        // leave margin after draining

    // Spare command codes; the block answers them with a plain status-ok.
    localparam logic [cdq_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [cdq_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    logic clk = 1'b0;
    logic rst_n;

    int send_idle;      // percent of cycles the sender holds valid low
    int recv_idle;      // percent of cycles the receiver holds ready low
    int stall_req;      // hand-off to the receiver process: cycles to hold off
    int n_sent;
    int cycles;

    int n_errors;
    int n_pending;
    int model_held;
    int n_full;
    int n_empty;
    int n_range;

    cdq_req_if req_ch();
    cdq_rsp_if rsp_ch();

    circular_deque_with_index_access_unit #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (cdq_pkg::VALUE_W)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    cdq_checker #(
        .DEPTH (DEPTH)
    ) checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .errors  (n_errors),
        .pending (n_pending),
        .held    (model_held),
        .n_full  (n_full),
        .n_empty (n_empty),
        .n_range (n_range)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Element values: mostly random, with the all-zero and all-one extremes mixed in.
    function automatic logic [cdq_pkg::VALUE_W-1:0] rand_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom();
    endfunction

    // Mostly a legal position in [lo, hi]; otherwise one of the boundary or
    // far-out positions, or any 12-bit value at all.
    function automatic int pick_index(int lo, int hi);
        int pick;
        if ($urandom_range(0, 99) < 80 && hi >= lo)
            pick = int'($urandom_range(hi - lo, 0)) + lo;
        else
            case ($urandom_range(0, 7))
                0:       pick = hi + 1;
                1:       pick = hi + 2;
                2:       pick = -1;
                3:       pick = -2;
                4:       pick = DEPTH;
                5:       pick = -2048;
                6:       pick = 2047;
                default: pick = int'($urandom_range(0, 4095)) - 2048;
            endcase
        return pick;
    endfunction

    // Index bits for commands that ignore the index: any 12-bit pattern.
    function automatic int junk_index();
        return int'($urandom_range(0, 4095)) - 2048;
    endfunction

    // Offers one command transaction. Inputs change on the falling edge only;
    // ready is looked at on the rising edge. Valid is left high on return so
    // that a back-to-back command needs just one assignment in that step.
    task automatic send_cmd(logic [cdq_pkg::CMD_W-1:0] c, int ix,
                            logic [cdq_pkg::VALUE_W-1:0] v);
        while ($urandom_range(0, 99) < send_idle)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd   <= c;
        req_ch.index <= ix[cdq_pkg::INDEX_W-1:0];
        req_ch.value <= v;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
        n_sent++;
    endtask

    // Random traffic. The push/pop mix leans on the current fill level: pushes win
    // below 8 elements and pops win above 40, so the deque mostly holds a few dozen or fewer.
    task automatic send_random();
        int sel;
        int push_w;
        sel    = $urandom_range(0, 99);
        push_w = (model_held < 8) ? 45 : ((model_held > 40) ? 15 : 30);
        if (sel < 3)
            send_cmd(($urandom_range(0, 1) != 0) ? CMD_SPARE_7 : CMD_SPARE_6,
                     junk_index(), rand_value());
        else if (sel < 3 + push_w)
            send_cmd(($urandom_range(0, 1) != 0) ? cdq_pkg::CMD_PUSH_FRONT
                                                 : cdq_pkg::CMD_PUSH_BACK,
                     junk_index(), rand_value());
        else if (sel < 63)
            send_cmd(($urandom_range(0, 1) != 0) ? cdq_pkg::CMD_POP_FRONT
                                                 : cdq_pkg::CMD_POP_BACK,
                     junk_index(), rand_value());
        else if (sel < 80)
            send_cmd(cdq_pkg::CMD_READ_AT, pick_index(0, model_held - 1), rand_value());
        else
            send_cmd(cdq_pkg::CMD_WRITE_AT, pick_index(-1, model_held), rand_value());
    endtask

    // Drop valid and wait for every outstanding response.
    task automatic wait_all_rsp();
        req_ch.valid <= 1'b0;
        while (n_pending != 0)
            @(negedge clk);
    endtask

    // Response side: random ready, or a long forced hold-off when one is asked.
    initial
    begin
        int left;
        left         = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_req > 0)
            begin
                left      = stall_req;
                stall_req = 0;
            end
            if (left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                left--;
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // Watchdog.
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d responses outstanding", cycles, n_pending);
        $display("circular_deque_with_index_access_unit test failed");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.cmd   = '0;
        req_ch.index = '0;
        req_ch.value = '0;
        send_idle    = 22;
        recv_idle    = 65;
        stall_req    = 0;
        n_sent       = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // ---- directed edges, starting from the empty deque ----
        send_cmd(cdq_pkg::CMD_POP_FRONT, 0, '0);              // pop front on empty
        send_cmd(cdq_pkg::CMD_POP_BACK, 0, '1);               // pop back on empty
        send_cmd(cdq_pkg::CMD_READ_AT, 0, '0);                // any read is out of range
        send_cmd(cdq_pkg::CMD_WRITE_AT, 1, 32'h1111_1111);    // past the end
        send_cmd(cdq_pkg::CMD_WRITE_AT, -2, 32'h2222_2222);   // below -1
        send_cmd(cdq_pkg::CMD_WRITE_AT, 0, 32'hFFFF_FFFF);    // empty: index 0 pushes back
        send_cmd(cdq_pkg::CMD_WRITE_AT, -1, 32'h0000_0000);   // -1 pushes front, head wraps
        send_cmd(cdq_pkg::CMD_PUSH_FRONT, -2048, 32'hA5A5_A5A5);
        send_cmd(cdq_pkg::CMD_PUSH_BACK, 2047, 32'h5A5A_5A5A);
        send_cmd(cdq_pkg::CMD_READ_AT, 0, '0);                // front
        send_cmd(cdq_pkg::CMD_READ_AT, 3, '0);                // back
        send_cmd(cdq_pkg::CMD_READ_AT, 4, '0);                // index == count
        send_cmd(cdq_pkg::CMD_READ_AT, -1, '0);
        send_cmd(cdq_pkg::CMD_READ_AT, 2047, '0);
        send_cmd(cdq_pkg::CMD_READ_AT, -2048, '0);
        send_cmd(cdq_pkg::CMD_WRITE_AT, 2, 32'h1234_5678);    // replace, returns old element
        send_cmd(cdq_pkg::CMD_WRITE_AT, DEPTH, 32'h0BAD_0BAD);
        send_cmd(cdq_pkg::CMD_WRITE_AT, 4, 32'h8765_4321);    // index == count pushes back
        send_cmd(CMD_SPARE_6, 0, '1);
        send_cmd(CMD_SPARE_7, -1, '1);
        send_cmd(cdq_pkg::CMD_POP_FRONT, 0, '0);
        send_cmd(cdq_pkg::CMD_POP_BACK, 0, '0);
        send_cmd(cdq_pkg::CMD_READ_AT, 1, '0);
        send_cmd(cdq_pkg::CMD_PUSH_BACK, 0, 32'hCAFE_F00D);

        // ---- random, sender mostly busy, receiver mostly stalled ----
        repeat (270) send_random();

        // ---- random, the other way round ----
        send_idle = 65;
        recv_idle = 22;
        repeat (270) send_random();

        // Sender pauses until the pipe has fully drained.
        wait_all_rsp();

        // ---- no idling, opened by a long receiver hold-off ----
        send_idle = 0;
        recv_idle = 0;
        stall_req = STALL_CYCLES;
        repeat (280) send_random();

        wait_all_rsp();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Sent %0d commands: directed edges and random traffic under three idle",
                 n_sent);
        $display("mixes with one long receiver hold-off; flagged full %0d, empty %0d, bad index %0d.",
                 n_full, n_empty, n_range);
        if (n_errors == 0)
            $display("circular_deque_with_index_access_unit test passed");
        else
            $display("circular_deque_with_index_access_unit test failed");
        $finish;
    end

endmodule

`default_nettype wire
